// ===== design/utf8t_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8t_pkg
// Shared types and constants for the phonetic UTF-8 to ASCII transliterator.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8t_pkg;

   localparam int unsigned MaxRun   = 5;   // longest expansion in characters
   localparam int unsigned RunCntW  = 3;   // holds 0 .. MaxRun
   localparam int unsigned CpW      = 11;  // two-byte code point width

   // lead byte of a two-byte sequence: 110xxxxx
   localparam logic [2:0] LeadPrefix = 3'b110;

   typedef logic [0:MaxRun-1][7:0] run_text_type;

   typedef struct packed {
      logic                 hit;
      logic [RunCntW-1:0]   len;
      run_text_type         text;
   } sym_type;

endpackage

`default_nettype wire

// ===== design/phonetic_utf8_to_ascii_transliterator_unit.sv =====
// ----------------------------------------------------------------------------
// phonetic_utf8_to_ascii_transliterator_unit
// Byte-stream transliterator: two-byte phonetic code points become ASCII.
// ----------------------------------------------------------------------------
// One input byte can be taken every cycle while no earlier run is pending.
// A plain byte yields one output byte; a lead byte (110xxxxx) yields nothing
// and is held until the next byte, which completes the pair. A listed
// phonetic code point expands to its 1..5 character spelling, any other
// pair is echoed as its two bytes. Output bytes leave one per cycle from a
// run register while rsp_ready is high; a new byte is taken in the same
// cycle the last byte of the previous run is transferred.
// rsp_last_of_run marks the final byte of each run.
`default_nettype none

module phonetic_utf8_to_ascii_transliterator_unit
   import utf8t_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_byte_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_last_of_run
);

   logic               lead_pending_ff, lead_pending_in;
   logic [4:0]         lead_bits_ff, lead_bits_in;
   logic [RunCntW-1:0] count_ff, count_in;
   run_text_type       text_ff, text_in;

   logic               req_fire, rsp_fire;
   logic [CpW-1:0]     cp;
   sym_type            sym;
   logic [RunCntW-1:0] new_len;
   run_text_type       new_text;

   assign cp = {lead_bits_ff, req_byte_in[5:0]};

   utf8t_symbol_rom u_rom (
      .cp  (cp),
      .sym (sym)
   );

   assign rsp_valid       = (count_ff != '0);
   assign rsp_out_char    = text_ff[0];
   assign rsp_last_of_run = (count_ff == RunCntW'(1));
   assign rsp_fire        = rsp_valid && rsp_ready;
   assign req_ready       = !rsp_valid || (rsp_last_of_run && rsp_ready);
   assign req_fire        = req_valid && req_ready;

   // build the run for the byte being accepted
   always_comb begin
      lead_pending_in = lead_pending_ff;
      lead_bits_in    = lead_bits_ff;
      new_len         = '0;
      new_text        = '0;
      if (!lead_pending_ff) begin
         if (req_byte_in[7:5] == LeadPrefix) begin
            lead_pending_in = req_fire ? 1'b1 : lead_pending_ff;
            lead_bits_in    = req_fire ? req_byte_in[4:0] : lead_bits_ff;
         end else begin
            new_len     = RunCntW'(1);
            new_text[0] = req_byte_in;
         end
      end else begin
         lead_pending_in = req_fire ? 1'b0 : lead_pending_ff;
         if (sym.hit) begin
            new_len  = sym.len;
            new_text = sym.text;
         end else begin
            // unlisted pair: echo lead and second byte
            new_len     = RunCntW'(2);
            new_text[0] = {LeadPrefix, lead_bits_ff};
            new_text[1] = req_byte_in;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      text_in  = text_ff;
      if (req_fire && (new_len != '0)) begin
         count_in = new_len;
         text_in  = new_text;
      end else if (rsp_fire) begin
         count_in = count_ff - RunCntW'(1);
         text_in  = {text_ff[1:MaxRun-1], 8'h00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
         count_ff        <= '0;
      end else begin
         lead_pending_ff <= lead_pending_in;
         count_ff        <= count_in;
      end
      lead_bits_ff <= lead_bits_in;
      text_ff      <= text_in;
   end

endmodule

`default_nettype wire

// ===== design/utf8t_symbol_rom.sv =====
// ----------------------------------------------------------------------------
// utf8t_symbol_rom
// Maps a two-byte code point to its phonetic ASCII spelling and length.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8t_symbol_rom
   import utf8t_pkg::*;
(
   input  wire logic [CpW-1:0] cp,
   output sym_type             sym
);

   always_comb begin
      sym.hit  = 1'b1;
      sym.len  = RunCntW'(0);
      sym.text = '0;
      unique case (cp)
         11'h0E6: begin sym.len = 3'd1; sym.text = {"@",     32'h0}; end
         11'h0F0: begin sym.len = 3'd3; sym.text = {"<Z>",   16'h0}; end
         11'h14B: begin sym.len = 3'd3; sym.text = {"<n>",   16'h0}; end
         11'h251: begin sym.len = 3'd1; sym.text = {"a",     32'h0}; end
         11'h252: begin sym.len = 3'd3; sym.text = {"<o>",   16'h0}; end
         11'h254: begin sym.len = 3'd1; sym.text = {"o",     32'h0}; end
         11'h259: begin sym.len = 3'd3; sym.text = {"<a>",   16'h0}; end
         11'h25B: begin sym.len = 3'd1; sym.text = {"e",     32'h0}; end
         11'h25C: begin sym.len = 3'd3; sym.text = {"<e>",   16'h0}; end
         11'h26A: begin sym.len = 3'd3; sym.text = {"<i>",   16'h0}; end
         11'h283: begin sym.len = 3'd4; sym.text = {"<sh>",  8'h0};  end
         11'h28A: begin sym.len = 3'd3; sym.text = {"<u>",   16'h0}; end
         11'h28C: begin sym.len = 3'd1; sym.text = {"^",     32'h0}; end
         11'h292: begin sym.len = 3'd3; sym.text = {"<z>",   16'h0}; end
         11'h2A4: begin sym.len = 3'd4; sym.text = {"<dz>",  8'h0};  end
         11'h2A7: begin sym.len = 3'd5; sym.text = "<tch>";          end
         11'h2C8: begin sym.len = 3'd1; sym.text = {"'",     32'h0}; end
         11'h2CC: begin sym.len = 3'd1; sym.text = {",",     32'h0}; end
         11'h2D0: begin sym.len = 3'd1; sym.text = {":",     32'h0}; end
         11'h3B8: begin sym.len = 3'd3; sym.text = {"<S>",   16'h0}; end
         default: begin sym.hit = 1'b0; end
      endcase
   end

endmodule

`default_nettype wire

// ===== tb/translit_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// translit_tb_pkg
// Scoreboard for the phonetic UTF-8 to ASCII transliterator testbench: keeps
// its own copy of the pending lead byte, spells out each accepted byte into
// the output bytes it should cause and checks the output stream in order.
// ----------------------------------------------------------------------------

package translit_tb_pkg;
   import utf8t_pkg::*;

   localparam int unsigned NumPhonetic = 20;

   // listed phonetic code points, used to build well-formed pairs
   localparam logic [CpW-1:0] PhoneticCps [NumPhonetic] = '{
      11'h0E6, 11'h0F0, 11'h14B, 11'h251, 11'h252, 11'h254, 11'h259,
      11'h25B, 11'h25C, 11'h26A, 11'h283, 11'h28A, 11'h28C, 11'h292,
      11'h2A4, 11'h2A7, 11'h2C8, 11'h2CC, 11'h2D0, 11'h3B8
   };

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } out_byte_type;

   class translit_scoreboard;
      out_byte_type  expected_bytes[$];
      bit            lead_held;
      logic [4:0]    lead_low;
      int unsigned   failures;

      function new();
         lead_held = 1'b0;
         lead_low  = '0;
         failures  = 0;
      endfunction

      // ascii spelling of a code point, empty when not listed
      static function string spelling(logic [CpW-1:0] cp);
         case (cp)
            11'h0E6: return "@";
            11'h0F0: return "<Z>";
            11'h14B: return "<n>";
            11'h251: return "a";
            11'h252: return "<o>";
            11'h254: return "o";
            11'h259: return "<a>";
            11'h25B: return "e";
            11'h25C: return "<e>";
            11'h26A: return "<i>";
            11'h283: return "<sh>";
            11'h28A: return "<u>";
            11'h28C: return "^";
            11'h292: return "<z>";
            11'h2A4: return "<dz>";
            11'h2A7: return "<tch>";
            11'h2C8: return "'";
            11'h2CC: return ",";
            11'h2D0: return ":";
            11'h3B8: return "<S>";
            default: return "";
         endcase
      endfunction

      function void fail_note(string msg);
         failures++;
         if (failures <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      function void note_byte(logic [7:0] b);
         string          sp;
         logic [CpW-1:0] cp;
         int             k;
         if (!lead_held) begin
            if (b[7:5] == LeadPrefix) begin
               lead_low  = b[4:0];
               lead_held = 1'b1;
            end else begin
               expected_bytes.push_back(out_byte_type'{ch: b, last: 1'b1});
            end
            return;
         end
         // second byte of a pair, taken without any continuation check
         lead_held = 1'b0;
         cp = {lead_low, b[5:0]};
         sp = spelling(cp);
         if (sp.len() == 0) begin
            expected_bytes.push_back(out_byte_type'{ch: {LeadPrefix, lead_low}, last: 1'b0});
            expected_bytes.push_back(out_byte_type'{ch: b, last: 1'b1});
         end else begin
            for (k = 0; k < sp.len(); k++)
               expected_bytes.push_back(out_byte_type'{ch: sp[k], last: (k == sp.len() - 1)});
         end
      endfunction

      function void check_out(logic [7:0] ch, logic last);
         out_byte_type want;
         if (expected_bytes.size() == 0) begin
            fail_note($sformatf("unexpected output byte %02h last %0b", ch, last));
            return;
         end
         want = expected_bytes.pop_front();
         if (ch !== want.ch || last !== want.last)
            fail_note($sformatf("mismatch: expected %02h last %0b, got %02h last %0b",
                                want.ch, want.last, ch, last));
      endfunction

      function int unsigned pending();
         return expected_bytes.size();
      endfunction

      function void check_drained();
         if (expected_bytes.size() != 0)
            fail_note($sformatf("%0d output bytes never arrived", expected_bytes.size()));
      endfunction
   endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the phonetic UTF-8 to ASCII transliterator unit.
// Feeds a directed byte sequence and then mostly well-formed two-byte
// sequences mixed with stray and broken bytes, under several patterns of
// sender idling and receiver stalls plus one long receiver hold-off, and
// checks every output byte and its end-of-run flag against a scoreboard.
// ----------------------------------------------------------------------------

module tb;
   import utf8t_pkg::*;
   import translit_tb_pkg::*;

   localparam int unsigned IdleLimit = 3000;
   localparam int unsigned HoldLen   = 200;
   localparam int unsigned PhaseLen  = 65;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_byte_in;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_char;
   logic       rsp_last_of_run;

   int unsigned send_idle_pct;
   int unsigned stall_pct;
   bit          hold_request;
   int unsigned bytes_sent;
   int unsigned quiet_cycles;

   translit_scoreboard sb;

   phonetic_utf8_to_ascii_transliterator_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_in     (req_byte_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, or one long hold-off when requested
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HoldLen - 1) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // both channels are sampled here so an input is noted before its output is checked
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_valid && req_ready) sb.note_byte(req_byte_in);
         if (rsp_valid && rsp_ready) sb.check_out(rsp_out_char, rsp_last_of_run);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= IdleLimit) begin
               $display("RESULT: ERROR");
               $finish;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_pair(input logic [CpW-1:0] cp, input logic [1:0] cont_top);
      send_byte({LeadPrefix, cp[10:6]});
      send_byte({cont_top, cp[5:0]});
   endtask

   // one random token: a listed pair, an arbitrary pair, a pair with a bad
   // continuation byte, or a single random byte
   task automatic send_token();
      int unsigned    pick;
      logic [CpW-1:0] cp;
      pick = $urandom_range(99);
      cp   = PhoneticCps[$urandom_range(NumPhonetic - 1)];
      if (pick < 45)
         send_pair(cp, 2'b10);
      else if (pick < 65)
         send_pair(11'($urandom), 2'($urandom));
      else if (pick < 75)
         send_pair(cp, 2'($urandom));
      else
         send_byte(8'($urandom));
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall);
      int unsigned stop_at;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      stop_at       = bytes_sent + PhaseLen;
      while (bytes_sent < stop_at) send_token();
   endtask

   localparam logic [7:0] Directed [24] = '{
      8'h00, 8'hFF, 8'h7F, 8'h80, 8'hE0,   // plain bytes pass through
      8'hC3, 8'hA6,                        // one character
      8'hCA, 8'hA7,                        // five characters
      8'hCA, 8'h83,                        // four characters
      8'hC5, 8'h8B,                        // three characters
      8'hCE, 8'hB8,
      8'hC3, 8'h26,                        // bad continuation still hits the table
      8'hC0, 8'h00,                        // unlisted, second byte not a continuation
      8'hDF, 8'hFF,
      8'hC3, 8'hC3,                        // second byte is itself a lead byte
      8'h41
   };

   initial begin
      sb            = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_byte_in   = 8'h00;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_request  = 1'b0;
      bytes_sent    = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (Directed[i]) send_byte(Directed[i]);

      run_phase(0, 0);
      run_phase(65, 0);
      run_phase(0, 65);

      // long receiver hold-off while the sender keeps offering bytes
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_request  = 1'b1;
      repeat (30) send_token();

      run_phase(16, 16);
      send_byte(8'h41);   // closes any pair left open
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      sb.check_drained();
      if (sb.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
